[design/pmc_pkg.sv]
// ---------------------------------------------------------------------------
// pmc_pkg: shared types and constants for the PS/2 mouse cursor unit
// Coordinate widths, header bit positions, register indexes and the
// packet phase type.
// ---------------------------------------------------------------------------
`default_nettype none

package pmc_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 12;
    localparam int OUT_BITS   = 12;
    localparam int BYTE_BITS  = 8;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int WIDE_BITS  = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;
    localparam int OUT_DATA_BITS = 32;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    // header bits
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    // configuration register indexes
    localparam logic REG_MAX_X = 1'b0;
    localparam logic REG_MAX_Y = 1'b1;

    localparam logic [CFG_BITS-1:0] MAX_X_RESET = CFG_BITS'(1023);
    localparam logic [CFG_BITS-1:0] MAX_Y_RESET = CFG_BITS'(767);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    // saturate a value to the coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [WIDE_BITS-1:0] v);
        logic [COORD_BITS-1:0] r;
        if (v > WIDE_BITS'(COORD_MAX))
            r = COORD_MAX;
        else
            r = COORD_BITS'(v);
        return r;
    endfunction

    localparam logic [COORD_BITS-1:0] POS_X_RESET = sat_coord(WIDE_BITS'(512));
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = sat_coord(WIDE_BITS'(384));

endpackage

`default_nettype wire

[design/pmc_axis_step.sv]
// ---------------------------------------------------------------------------
// pmc_axis_step: one cursor axis update
// Sign-extend a 9-bit delta, add or subtract it (or hold when move is low), clamp to 0..bound.
// ---------------------------------------------------------------------------
`default_nettype none

module pmc_axis_step (
    input  wire logic [pmc_pkg::COORD_BITS-1:0] pos,
    input  wire logic [pmc_pkg::BYTE_BITS-1:0]  delta_low,
    input  wire logic                           delta_sign,
    input  wire logic                           subtract,
    input  wire logic                           move,
    input  wire logic [pmc_pkg::CFG_BITS-1:0]   bound,
    output logic      [pmc_pkg::COORD_BITS-1:0] pos_next
);
    import pmc_pkg::*;

    logic signed [SUM_BITS-1:0] pos_ext;
    logic signed [SUM_BITS-1:0] delta_ext;
    logic signed [SUM_BITS-1:0] sum;
    logic        [COORD_BITS-1:0] bound_sat;

    assign pos_ext   = signed'({2'b00, pos});
    assign delta_ext = SUM_BITS'(signed'({delta_sign, delta_low}));
    assign bound_sat = sat_coord(WIDE_BITS'(bound));

    always_comb
    begin
        if (!move)
            sum = pos_ext;
        else if (subtract)
            sum = pos_ext - delta_ext;
        else
            sum = pos_ext + delta_ext;

        if (sum < 0)
            pos_next = '0;
        else if (sum > signed'({2'b00, bound_sat}))
            pos_next = bound_sat;
        else
            pos_next = COORD_BITS'(sum);
    end

endmodule

`default_nettype wire

[design/ps2_mouse_packet_cursor_unit.sv]
// ---------------------------------------------------------------------------
// ps2_mouse_packet_cursor_unit: PS/2 mouse packet decoder with clamped cursor
// Frames 3-byte mouse packets and tracks a bounded screen cursor.
// ---------------------------------------------------------------------------
// Usage:
//   Feed raw mouse bytes on the s_axis channel, one byte per word. A byte
//   opens a packet only when its sync bit (bit 3) is set; other bytes are
//   dropped while hunting for a header. The second and third bytes carry
//   the X and Y deltas. Each completed packet produces one word on m_axis
//   with the clamped cursor, the three buttons and a motion_dropped flag
//   that is set when an overflow bit made the unit ignore the movement.
//   Write max_x (index 0) and max_y (index 1) through cfg_we/cfg_index/
//   cfg_data only while the unit is idle.
// Timing:
//   One byte per cycle sustained while the receiver takes results. Each
//   byte is decoded while it sits in the input register; the result word
//   is registered from the decode of the third byte. The rate is set by
//   the single decode stage between input register and result register.
// Reset and stall:
//   Reset clears the phase to header hunt, the cursor to (512, 384) and
//   the bounds to 1023 x 767. When the receiver stalls, the result register
//   holds its word and bytes keep flowing until the next packet's third
//   byte waits in the input register; then s_axis_tready drops until the
//   result drains.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_cursor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] aux_byte
    // stream output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [11:0] cursor_x, [23:12] cursor_y,
                                             // [24] button_left, [25] button_right,
                                             // [26] button_middle, [27] motion_dropped
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [pmc_pkg::CFG_BITS-1:0] cfg_data
);
    import pmc_pkg::*;

    // configuration
    logic [CFG_BITS-1:0] max_x_reg;
    logic [CFG_BITS-1:0] max_y_reg;

    // input register
    logic                 in_valid_reg;
    logic [BYTE_BITS-1:0] in_byte_reg;

    // packet state
    phase_t               phase_reg, phase_next;
    logic [BYTE_BITS-1:0] header_reg;
    logic [BYTE_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;

    // result register
    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;

    logic out_free;
    logic fire;
    logic load_header;
    logic load_dx;
    logic emit;
    logic overflow;
    logic [COORD_BITS-1:0] pos_x_new;
    logic [COORD_BITS-1:0] pos_y_new;

    // result slot frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_axis_tready;
    // decode the held byte unless it completes a packet with nowhere to go
    assign fire = in_valid_reg && ((phase_reg != PH_DY) || out_free);
    assign s_axis_tready = !in_valid_reg || fire;

    assign overflow = header_reg[HDR_XOVF] || header_reg[HDR_YOVF];

    // --- configuration writes ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_RESET;
            max_y_reg <= MAX_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                default:   max_x_reg <= max_x_reg;
            endcase
        end
    end

    // --- input register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    // --- packet phase ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_HEADER;
        else
            phase_reg <= phase_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        load_header = 1'b0;
        load_dx     = 1'b0;
        emit        = 1'b0;
        if (fire)
        begin
            case (phase_reg)
                PH_DX:
                begin
                    load_dx    = 1'b1;
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    emit       = 1'b1;
                    phase_next = PH_HEADER;
                end
                default:
                begin
                    // hunt for a byte with the sync bit set
                    if (in_byte_reg[HDR_SYNC])
                    begin
                        load_header = 1'b1;
                        phase_next  = PH_DX;
                    end
                    else
                        phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_header)
            header_reg <= in_byte_reg;
        if (load_dx)
            dx_reg <= in_byte_reg;
    end

    // --- cursor arithmetic ---
    pmc_axis_step u_step_x (
        .pos        (pos_x_reg),
        .delta_low  (dx_reg),
        .delta_sign (header_reg[HDR_XSIGN]),
        .subtract   (1'b0),
        .move       (!overflow),
        .bound      (max_x_reg),
        .pos_next   (pos_x_new)
    );

    // Y counts up on the mouse, down on screen: subtract it
    pmc_axis_step u_step_y (
        .pos        (pos_y_reg),
        .delta_low  (in_byte_reg),
        .delta_sign (header_reg[HDR_YSIGN]),
        .subtract   (1'b1),
        .move       (!overflow),
        .bound      (max_y_reg),
        .pos_next   (pos_y_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= POS_X_RESET;
            pos_y_reg <= POS_Y_RESET;
        end
        else if (emit)
        begin
            pos_x_reg <= pos_x_new;
            pos_y_reg <= pos_y_new;
        end
    end

    // --- result register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {4'b0000,
                             overflow,
                             header_reg[HDR_MIDDLE],
                             header_reg[HDR_RIGHT],
                             header_reg[HDR_LEFT],
                             OUT_BITS'(pos_y_new),
                             OUT_BITS'(pos_x_new)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[design/pmc_checker.sv]
// ---------------------------------------------------------------------------
// pmc_checker: port-level checks for the PS/2 mouse cursor unit
// Watches the result channel and the bounds written through configuration.
// ---------------------------------------------------------------------------
`default_nettype none

module pmc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        cfg_we,
    input wire logic        cfg_index,
    input wire logic [pmc_pkg::CFG_BITS-1:0] cfg_data
);
    import pmc_pkg::*;

    logic [CFG_BITS-1:0] max_x_reg;
    logic [CFG_BITS-1:0] max_y_reg;

    // shadow the bounds seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_RESET;
            max_y_reg <= MAX_Y_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_X)
                max_x_reg <= cfg_data;
            else
                max_y_reg <= cfg_data;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:0] <= max_x_reg))
        else $error("cursor_x above max_x");

    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:12] <= max_y_reg))
        else $error("cursor_y above max_y");

endmodule

bind ps2_mouse_packet_cursor_unit pmc_checker u_pmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

`default_nettype wire
